// ===== sv/dmsw_pkg.sv =====
`default_nettype none
package dmsw_pkg;

  localparam int OUT_TIME_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_PING = 2'd1;
  localparam logic [1:0] CMD_ARM  = 2'd2;

  localparam logic [2:0] ACT_PONG      = 3'd0;
  localparam logic [2:0] ACT_START     = 3'd1;
  localparam logic [2:0] ACT_DEPTH_OFF = 3'd2;
  localparam logic [2:0] ACT_HEAD_OFF  = 3'd3;
  localparam logic [2:0] ACT_STOP      = 3'd4;
  localparam logic [2:0] ACT_LIGHT     = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_BOOT_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT      = 2'd3;

  localparam logic [15:0] RST_BOOT_DELAY = 16'd15000;
  localparam logic [15:0] RST_TIMEOUT    = 16'd2000;
  localparam logic [15:0] RST_BLINK      = 16'd500;
  localparam logic [7:0]  RST_LIGHT      = 8'd50;

  // one bit per result, lowest bit goes out first
  localparam int RES_START = 0;
  localparam int RES_PONG  = 1;
  localparam int RES_DEPTH = 2;
  localparam int RES_HEAD  = 3;
  localparam int RES_STOP  = 4;
  localparam int RES_LIGHT = 5;
  localparam int RES_N     = 6;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] arg;
  } in_item_t;

  typedef struct packed {
    logic [2:0]              action;
    logic signed [15:0]      value;
    logic [OUT_TIME_W-1:0]   time_ms;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic                    start;
    logic                    pong;
    logic                    trip;
    logic                    light;
    logic signed [15:0]      arg;
    logic [7:0]              light_val;
    logic [OUT_TIME_W-1:0]   time_ms;
  } event_t;

endpackage
`default_nettype wire

// ===== sv/dead_man_switch_watchdog_core.sv =====
// dead-man watchdog core
// input queue side: present in_item and raise in_push; the item is taken on a
// clock edge with in_full low. cmd tick advances the millisecond count, ping
// echoes arg as a pong, arm/disarm sets the arm flag from arg.
// result queue side: while out_empty is low the oldest result sits on
// out_item; raise out_pop to take it. last marks the final result of an item.
// configuration: cfg_index/cfg_data written when cfg_valid is high; cfg_ready
// is always high. write only while the block is idle.
// timing: an item is classified and its state updated on the edge that takes
// it; its event enters the event queue on that edge. the result stage takes
// it once all earlier results are popped and then sends its results on
// out_item, one per cycle while out_pop is high; an item has up to 4
// results. a two-entry event queue sits between classifier and result stage;
// items with no results skip it and are taken at one per cycle while it is
// not full, and the input still takes items while results wait to be popped.
// reset: counters, timers and flags clear, registers return to their defaults
// and both queues empty. a stalled result side fills the event queue and
// then raises in_full.
`default_nettype none
module dead_man_switch_watchdog_core import dmsw_pkg::*; #(
  parameter int TIME_WIDTH = 32
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_push,
  output logic                   in_full,
  input  in_item_t               in_item,
  output logic                   out_empty,
  input  wire                    out_pop,
  output out_item_t              out_item,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire  [CFG_IDX_W-1:0]   cfg_index,
  input  wire  [CFG_DATA_W-1:0]  cfg_data
);

  event_t ev, q_head;
  logic   ev_valid, q_full, q_empty, q_pop;

  assign in_full   = q_full;
  assign cfg_ready = 1'b1;

  dmsw_front #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .q_full    (q_full),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ev_valid  (ev_valid),
    .ev        (ev)
  );

  dmsw_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (ev_valid),
    .push_ev (ev),
    .pop     (q_pop),
    .head_ev (q_head),
    .empty   (q_empty),
    .full    (q_full)
  );

  dmsw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ===== sv/dmsw_front.sv =====
`default_nettype none
module dmsw_front import dmsw_pkg::*; #(
  parameter int TIME_WIDTH = 32
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_push,
  input  in_item_t                    in_item,
  input  wire                         q_full,
  input  wire                         cfg_valid,
  input  wire  [CFG_IDX_W-1:0]        cfg_index,
  input  wire  [CFG_DATA_W-1:0]       cfg_data,
  output logic                        ev_valid,
  output event_t                      ev
);

  logic [15:0]           boot_delay_r;
  logic [15:0]           timeout_r;
  logic [15:0]           blink_r;
  logic [7:0]            light_r;

  logic [TIME_WIDTH-1:0] now_r, now_nxt;
  logic [TIME_WIDTH-1:0] wstart_r, wstart_nxt;
  logic [TIME_WIDTH-1:0] bstart_r, bstart_nxt;
  logic                  armed_r, armed_nxt;
  logic                  tripped_r, tripped_nxt;
  logic                  phase_r, phase_nxt;

  logic                  accept;
  logic                  is_ping;
  logic                  armed_a;
  logic [TIME_WIDTH-1:0] wstart_p;
  logic                  tripped_p;
  logic [TIME_WIDTH-1:0] wdiff, bdiff;
  logic                  wfire, trip_ev, lfire, start_ev;
  logic [OUT_TIME_W-1:0] time32;

  assign accept  = in_push && !q_full;
  assign is_ping = (in_item.cmd == CMD_PING);

  always_comb begin
    now_nxt   = (in_item.cmd == CMD_TICK) ? now_r + {{(TIME_WIDTH-1){1'b0}}, 1'b1} : now_r;
    armed_a   = armed_r || (now_nxt > {{(TIME_WIDTH-16){1'b0}}, boot_delay_r});
    wstart_p  = is_ping ? now_nxt : wstart_r;
    start_ev  = is_ping && tripped_r;
    tripped_p = is_ping ? 1'b0 : tripped_r;
    wdiff     = now_nxt - wstart_p;
    wfire     = wdiff > {{(TIME_WIDTH-16){1'b0}}, timeout_r};
    wstart_nxt = wfire ? now_nxt : wstart_p;
    trip_ev   = wfire && armed_a && !tripped_p;
    tripped_nxt = tripped_p || trip_ev;
    bdiff     = now_nxt - bstart_r;
    lfire     = tripped_nxt && (bdiff > {{(TIME_WIDTH-16){1'b0}}, blink_r});
    bstart_nxt = lfire ? now_nxt : bstart_r;
    phase_nxt = phase_r ^ lfire;
    armed_nxt = (in_item.cmd == CMD_ARM) ? (in_item.arg != 16'sd0) : armed_a;
  end

  generate
    if (TIME_WIDTH >= OUT_TIME_W) begin : g_wide
      assign time32 = now_nxt[OUT_TIME_W-1:0];
    end else begin : g_narrow
      assign time32 = {{(OUT_TIME_W-TIME_WIDTH){1'b0}}, now_nxt};
    end
  endgenerate

  always_comb begin
    ev.start     = start_ev;
    ev.pong      = is_ping;
    ev.trip      = trip_ev;
    ev.light     = lfire;
    ev.arg       = in_item.arg;
    ev.light_val = phase_r ? 8'd0 : light_r;
    ev.time_ms   = time32;
    ev_valid     = accept && (is_ping || trip_ev || lfire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boot_delay_r <= RST_BOOT_DELAY;
      timeout_r    <= RST_TIMEOUT;
      blink_r      <= RST_BLINK;
      light_r      <= RST_LIGHT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BOOT_DELAY: boot_delay_r <= cfg_data;
        REG_TIMEOUT:    timeout_r    <= cfg_data;
        REG_BLINK:      blink_r      <= cfg_data;
        REG_LIGHT:      light_r      <= cfg_data[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r     <= '0;
      wstart_r  <= '0;
      bstart_r  <= '0;
      armed_r   <= 1'b0;
      tripped_r <= 1'b0;
      phase_r   <= 1'b0;
    end else if (accept) begin
      now_r     <= now_nxt;
      wstart_r  <= wstart_nxt;
      bstart_r  <= bstart_nxt;
      armed_r   <= armed_nxt;
      tripped_r <= tripped_nxt;
      phase_r   <= phase_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/dmsw_queue.sv =====
`default_nettype none
module dmsw_queue import dmsw_pkg::*; (
  input  wire     clk,
  input  wire     rst_n,
  input  wire     push,
  input  event_t  push_ev,
  input  wire     pop,
  output event_t  head_ev,
  output logic    empty,
  output logic    full
);

  event_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic                do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head_ev = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/dmsw_back.sv =====
`default_nettype none
module dmsw_back import dmsw_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  event_t     q_head,
  input  wire        q_empty,
  output logic       q_pop,
  output logic       out_empty,
  input  wire        out_pop,
  output out_item_t  out_item
);

  logic [RES_N-1:0]      mask_r, mask_nxt;
  logic [RES_N-1:0]      cur, rest, remain, fresh;
  logic signed [15:0]    arg_r;
  logic [7:0]            light_val_r;
  logic [OUT_TIME_W-1:0] time_r;
  logic                  adv;

  assign cur    = mask_r & (~mask_r + 1'b1);
  assign rest   = mask_r & ~cur;
  assign adv    = out_pop && (mask_r != '0);
  assign remain = adv ? rest : mask_r;
  assign q_pop  = (remain == '0) && !q_empty;

  always_comb begin
    fresh            = '0;
    fresh[RES_START] = q_head.start;
    fresh[RES_PONG]  = q_head.pong;
    fresh[RES_DEPTH] = q_head.trip;
    fresh[RES_HEAD]  = q_head.trip;
    fresh[RES_STOP]  = q_head.trip;
    fresh[RES_LIGHT] = q_head.light;
    mask_nxt         = q_pop ? fresh : remain;
  end

  assign out_empty = (mask_r == '0);

  always_comb begin
    out_item.value   = 16'sd0;
    out_item.time_ms = time_r;
    out_item.last    = (rest == '0);
    priority if (mask_r[RES_START]) begin
      out_item.action = ACT_START;
    end else if (mask_r[RES_PONG]) begin
      out_item.action = ACT_PONG;
      out_item.value  = arg_r;
    end else if (mask_r[RES_DEPTH]) begin
      out_item.action = ACT_DEPTH_OFF;
    end else if (mask_r[RES_HEAD]) begin
      out_item.action = ACT_HEAD_OFF;
    end else if (mask_r[RES_STOP]) begin
      out_item.action = ACT_STOP;
    end else begin
      out_item.action = ACT_LIGHT;
      out_item.value  = {8'd0, light_val_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      arg_r       <= q_head.arg;
      light_val_r <= q_head.light_val;
      time_r      <= q_head.time_ms;
    end
  end

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dmsw_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n;
  logic in_push;
  logic in_full;
  in_item_t in_item;
  logic out_empty;
  logic out_pop;
  out_item_t out_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor copy of the switch
  logic [31:0] cur_ms, wd_mark, blink_mark;
  logic is_armed, is_tripped, light_phase;
  logic [15:0] boot_delay, trip_timeout, blink_period;
  logic [7:0] light_lvl;

  out_item_t pending_actions[$];
  int step_count;
  int err_cnt;
  int quiet_cycles;
  int burst_left;
  int pop_run, pop_mode;
  int cmd_seen[4];
  int result_cnt, trip_cnt, light_cnt, cfg_cnt;

  always #2 clk = ~clk;

  dead_man_switch_watchdog_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic void note_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("mismatch %0d: %s", err_cnt, msg);
    end
  endfunction

  function automatic void add_action(logic [2:0] act, logic [15:0] val);
    out_item_t r;
    r.action = act;
    r.value = val;
    r.time_ms = cur_ms;
    r.last = 1'b0;
    pending_actions.push_back(r);
    step_count++;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_cnt++;
    case (idx)
      REG_BOOT_DELAY: boot_delay = val;
      REG_TIMEOUT:    trip_timeout = val;
      REG_BLINK:      blink_period = val;
      REG_LIGHT:      light_lvl = val[7:0];
      default: ;
    endcase
  endfunction

  function automatic void predict_watchdog(in_item_t it);
    logic [31:0] diff;
    logic fired;
    step_count = 0;
    cmd_seen[it.cmd]++;
    if (it.cmd == CMD_TICK) cur_ms = cur_ms + 32'd1;
    if (!is_armed && cur_ms > {16'd0, boot_delay}) is_armed = 1'b1;
    if (it.cmd == CMD_PING) begin
      wd_mark = cur_ms;
      if (is_tripped) begin
        add_action(ACT_START, 16'd0);
        is_tripped = 1'b0;
      end
      add_action(ACT_PONG, it.arg);
    end
    diff = cur_ms - wd_mark;
    fired = diff > {16'd0, trip_timeout};
    if (fired) wd_mark = cur_ms;
    if (fired && is_armed && !is_tripped) begin
      add_action(ACT_DEPTH_OFF, 16'd0);
      add_action(ACT_HEAD_OFF, 16'd0);
      add_action(ACT_STOP, 16'd0);
      is_tripped = 1'b1;
      trip_cnt++;
    end
    if (is_tripped) begin
      diff = cur_ms - blink_mark;
      if (diff > {16'd0, blink_period}) begin
        blink_mark = cur_ms;
        add_action(ACT_LIGHT, light_phase ? 16'd0 : {8'd0, light_lvl});
        light_phase = !light_phase;
        light_cnt++;
      end
    end
    if (it.cmd == CMD_ARM) is_armed = (it.arg != 16'd0);
    if (step_count > 0) pending_actions[pending_actions.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_push && !in_full) predict_watchdog(in_item);
    end
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_pop && !out_empty) begin
      result_cnt++;
      if (pending_actions.size() == 0) begin
        note_error($sformatf("unexpected result action %0d value %0d time %0d last %0b",
                             out_item.action, out_item.value, out_item.time_ms,
                             out_item.last));
      end else begin
        exp_r = pending_actions.pop_front();
        if (out_item.action !== exp_r.action || out_item.value !== exp_r.value ||
            out_item.time_ms !== exp_r.time_ms || out_item.last !== exp_r.last) begin
          note_error($sformatf({"action %0d/%0d value %0d/%0d time %0d/%0d last %0b/%0b",
                                " (expected/actual)"},
                               exp_r.action, out_item.action, exp_r.value, out_item.value,
                               exp_r.time_ms, out_item.time_ms, exp_r.last, out_item.last));
        end
      end
    end
  end

  // receiver: always take, coin toss, mostly stalled, or fully stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_run <= 0;
      pop_mode <= 0;
    end else begin
      if (pop_run == 0) begin
        pop_mode <= $urandom_range(0, 3);
        pop_run <= $urandom_range(4, 30);
      end else begin
        pop_run <= pop_run - 1;
      end
      case (pop_mode)
        0: out_pop <= 1'b1;
        1: out_pop <= 1'($urandom_range(0, 1));
        2: out_pop <= ($urandom_range(0, 7) == 0);
        default: out_pop <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_push && !in_full) || (out_pop && !out_empty) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_item(logic [1:0] cmd, logic [15:0] arg);
    in_item_t it;
    it.cmd = cmd;
    it.arg = arg;
    in_item <= it;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 15);
    end
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_actions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_watchdog(logic [15:0] boot, logic [15:0] tmo, logic [15:0] blink,
                                  logic [15:0] light);
    logic [CFG_DATA_W-1:0] vals[4];
    vals = '{boot, tmo, blink, light};
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // pongs at the arg extremes under the reset settings, spare code, disarm
  task automatic test_ping_echo();
    push_item(CMD_PING, 16'h8000);
    push_item(CMD_PING, 16'h7fff);
    push_item(CMD_PING, 16'h0000);
    push_item(CMD_PING, 16'hffff);
    push_item(CMD_SPARE, 16'h5a5a);
    push_item(CMD_ARM, 16'h0000);
    push_item(CMD_TICK, 16'ha5a5);
    push_item(CMD_TICK, 16'h0000);
  endtask

  // short timers: auto-arm, trip, blink, restart by ping, one-item disarm
  task automatic test_trip_and_blink();
    program_watchdog(16'd2, 16'd3, 16'd1, 16'hc3ff);
    repeat (6) push_item(CMD_TICK, 16'h0000);
    push_item(CMD_SPARE, 16'h0000);
    push_item(CMD_TICK, 16'h0000);
    push_item(CMD_PING, 16'h1234);
    push_item(CMD_ARM, 16'h0000);
    repeat (5) push_item(CMD_TICK, 16'h0000);
    push_item(CMD_ARM, 16'h8000);
    repeat (2) push_item(CMD_TICK, 16'hffff);
  endtask

  task automatic test_random();
    int ping_pct, r;
    logic [1:0] cmd;
    logic [15:0] arg;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: program_watchdog(16'd0, 16'd0, 16'd0, 16'd0);
        5: program_watchdog(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        default: program_watchdog(16'($urandom_range(0, 30)), 16'($urandom_range(1, 12)),
                                  16'($urandom_range(1, 6)), 16'($urandom));
      endcase
      ping_pct = $urandom_range(3, 30);
      for (int n = 0; n < 55; n++) begin
        r = $urandom_range(0, 99);
        arg = 16'($urandom);
        if (r < ping_pct) begin
          cmd = CMD_PING;
        end else if (r < ping_pct + 10) begin
          cmd = CMD_ARM;
          if ($urandom_range(0, 1) == 0) arg = 16'd0;
        end else if (r < ping_pct + 16) begin
          cmd = CMD_SPARE;
        end else begin
          cmd = CMD_TICK;
        end
        push_item(cmd, arg);
        // hold off mid-phase until everything has come out
        if (ph == 2 && n == 27) wait_drained();
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cur_ms = '0;
    wd_mark = '0;
    blink_mark = '0;
    is_armed = 1'b0;
    is_tripped = 1'b0;
    light_phase = 1'b0;
    boot_delay = RST_BOOT_DELAY;
    trip_timeout = RST_TIMEOUT;
    blink_period = RST_BLINK;
    light_lvl = RST_LIGHT;
    err_cnt = 0;
    burst_left = 0;
    result_cnt = 0;
    trip_cnt = 0;
    light_cnt = 0;
    cfg_cnt = 0;
    cmd_seen = '{0, 0, 0, 0};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ping_echo();
    test_trip_and_blink();
    test_random();
    wait_drained();

    if (pending_actions.size() != 0) begin
      note_error($sformatf("%0d expected results never came", pending_actions.size()));
    end
    $display("items: %0d ticks, %0d pings, %0d arm/disarm, %0d spare; %0d register writes",
             cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], cfg_cnt);
    $display("results checked: %0d, with %0d trips and %0d light toggles, %0d mismatches",
             result_cnt, trip_cnt, light_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/dmsw_pkg.sv
sv/dmsw_front.sv
sv/dmsw_queue.sv
sv/dmsw_back.sv
sv/dead_man_switch_watchdog_core.sv
sim/tb.sv
